>>> hdl/pts_pkg.sv
`default_nettype none

package pts_pkg;

	// Table size and burst width
	localparam int MAX_PROCESSES = 16;
	localparam int BURST_BITS    = 16;

	// Field widths
	localparam int IN_BURST_W  = 16;
	localparam int BURST_W     = (BURST_BITS < IN_BURST_W) ? BURST_BITS : IN_BURST_W;
	localparam int PRI_W       = 16;
	localparam int IDX_W       = $clog2(MAX_PROCESSES);
	localparam int CNT_W       = $clog2(MAX_PROCESSES + 1);
	localparam int OUT_IDX_W   = 4;
	localparam int TIME_W      = 21;
	localparam int FIELD_W     = 20;
	localparam int SUM_W       = 24;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [BURST_W-1:0]   burst_t;
	typedef logic [PRI_W-1:0]     prio_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TIME_W-1:0]    time_t;
	typedef logic [FIELD_W-1:0]   field_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [OUT_IDX_W-1:0] out_idx_t;
	typedef logic [QPTR_W-1:0]    qptr_t;
	typedef logic [QCNT_W-1:0]    qcnt_t;

	// Input mode codes
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Classified commands
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		burst_t    burst;
		prio_t     prio;
	} cmd_t;

	// Back-end status
	typedef struct packed {
		logic idle;
		cnt_t entry_count;
		cnt_t done_count;
	} sts_t;

endpackage

`default_nettype wire

>>> hdl/pts_front.sv
`default_nettype none

module pts_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      mode,
	input  wire logic [15:0]     burst_time,
	input  wire logic [15:0]     priority_req,
	output logic                 cmd_valid,
	input  wire logic            cmd_ready,
	output pts_pkg::cmd_t        cmd
);

	pts_pkg::cmd_t  cmd_in;
	logic           keep;
	logic           push;
	logic           pop;
	pts_pkg::cmd_t  fifo_q [pts_pkg::QUEUE_DEPTH];
	pts_pkg::qptr_t wr_ptr_q;
	pts_pkg::qptr_t rd_ptr_q;
	pts_pkg::qcnt_t count_q;

	// Classify the item; drop unused modes and zero-length loads
	always_comb begin
		keep          = 1'b1;
		cmd_in.kind   = pts_pkg::CMD_TICK;
		cmd_in.burst  = burst_time[pts_pkg::BURST_W-1:0];
		cmd_in.prio   = priority_req;
		unique case (pts_pkg::mode_t'(mode))
			pts_pkg::MODE_CLEAR: begin
				cmd_in.kind = pts_pkg::CMD_CLEAR;
			end
			pts_pkg::MODE_LOAD: begin
				cmd_in.kind = pts_pkg::CMD_LOAD;
				keep        = (cmd_in.burst != '0);
			end
			pts_pkg::MODE_TICK: begin
				cmd_in.kind = pts_pkg::CMD_TICK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = (count_q != pts_pkg::qcnt_t'(pts_pkg::QUEUE_DEPTH));
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_ptr_q];

	// Advance queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pts_pkg::qptr_t'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pts_pkg::qptr_t'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + pts_pkg::qcnt_t'(1);
				2'b01:   count_q <= count_q - pts_pkg::qcnt_t'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the classified command
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

>>> hdl/pts_back.sv
`default_nettype none

module pts_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire pts_pkg::cmd_t   cmd,
	output pts_pkg::sts_t        sts,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [3:0]           process_index,
	output logic [19:0]          waiting_time,
	output logic [19:0]          turnaround_time,
	output logic [23:0]          total_wait,
	output logic [23:0]          total_turnaround,
	output logic                 all_done
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_STEP = 5'b00100,
		ST_CALC = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t          state_q;
	pts_pkg::cnt_t   entry_count_q;
	pts_pkg::cnt_t   done_count_q;
	pts_pkg::time_t  time_q;
	pts_pkg::sum_t   wait_sum_q;
	pts_pkg::sum_t   tat_sum_q;
	pts_pkg::idx_t   idx_q;
	logic            found_q;
	logic            out_valid_q;

	pts_pkg::burst_t burst_mem_q [pts_pkg::MAX_PROCESSES];
	pts_pkg::prio_t  prio_mem_q  [pts_pkg::MAX_PROCESSES];
	pts_pkg::burst_t rem_mem_q   [pts_pkg::MAX_PROCESSES];

	pts_pkg::idx_t   pick_q;
	pts_pkg::prio_t  best_pri_q;
	pts_pkg::burst_t pick_rem_q;
	pts_pkg::burst_t pick_burst_q;
	pts_pkg::field_t wt_q;
	pts_pkg::field_t tat_q;

	pts_pkg::out_idx_t out_idx_q;
	pts_pkg::field_t   out_wt_q;
	pts_pkg::field_t   out_tat_q;
	pts_pkg::sum_t     out_wsum_q;
	pts_pkg::sum_t     out_tsum_q;
	logic              out_done_q;

	logic            table_full;
	logic            take;
	logic            scan_last;
	logic            emit_go;
	pts_pkg::field_t wt_nxt;
	pts_pkg::sum_t   wait_sum_nxt;
	pts_pkg::sum_t   tat_sum_nxt;
	logic            all_done_nxt;

	// Scan compare, emit gating and result arithmetic
	assign table_full   = (entry_count_q == pts_pkg::cnt_t'(pts_pkg::MAX_PROCESSES));
	assign take         = (rem_mem_q[idx_q] != '0) &&
	                      (!found_q || (prio_mem_q[idx_q] < best_pri_q));
	assign scan_last    = ((pts_pkg::cnt_t'(idx_q) + pts_pkg::cnt_t'(1)) == entry_count_q);
	assign emit_go      = !out_valid_q || out_ready;
	assign wt_nxt       = pts_pkg::field_t'(time_q - pts_pkg::time_t'(pick_burst_q));
	assign wait_sum_nxt = wait_sum_q + pts_pkg::sum_t'(wt_q);
	assign tat_sum_nxt  = tat_sum_q + pts_pkg::sum_t'(tat_q);
	assign all_done_nxt = ((done_count_q + pts_pkg::cnt_t'(1)) == entry_count_q);

	assign cmd_ready = (state_q == ST_IDLE);

	// Sequence commands: clear, load, and the tick scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			done_count_q  <= '0;
			time_q        <= '0;
			wait_sum_q    <= '0;
			tat_sum_q     <= '0;
			idx_q         <= '0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// Raise valid on a new result, drop it once transferred
			if ((state_q == ST_EMIT) && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							pts_pkg::CMD_CLEAR: begin
								entry_count_q <= '0;
								done_count_q  <= '0;
								time_q        <= '0;
								wait_sum_q    <= '0;
								tat_sum_q     <= '0;
							end
							pts_pkg::CMD_LOAD: begin
								if (!table_full) begin
									entry_count_q <= entry_count_q + pts_pkg::cnt_t'(1);
								end
							end
							pts_pkg::CMD_TICK: begin
								if (entry_count_q != '0) begin
									idx_q   <= '0;
									found_q <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
					idx_q <= idx_q + pts_pkg::idx_t'(1);
					if (scan_last) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (!found_q) begin
						state_q <= ST_IDLE;
					end else begin
						time_q  <= time_q + pts_pkg::time_t'(1);
						state_q <= (pick_rem_q == pts_pkg::burst_t'(1)) ? ST_CALC : ST_IDLE;
					end
				end
				ST_CALC: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						wait_sum_q   <= wait_sum_nxt;
						tat_sum_q    <= tat_sum_nxt;
						done_count_q <= done_count_q + pts_pkg::cnt_t'(1);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table writes, scan winner, and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && (cmd.kind == pts_pkg::CMD_LOAD) && !table_full) begin
					burst_mem_q[entry_count_q[pts_pkg::IDX_W-1:0]] <= cmd.burst;
					prio_mem_q[entry_count_q[pts_pkg::IDX_W-1:0]]  <= cmd.prio;
					rem_mem_q[entry_count_q[pts_pkg::IDX_W-1:0]]   <= cmd.burst;
				end
			end
			ST_SCAN: begin
				if (take) begin
					pick_q       <= idx_q;
					best_pri_q   <= prio_mem_q[idx_q];
					pick_rem_q   <= rem_mem_q[idx_q];
					pick_burst_q <= burst_mem_q[idx_q];
				end
			end
			ST_STEP: begin
				if (found_q) begin
					rem_mem_q[pick_q] <= pick_rem_q - pts_pkg::burst_t'(1);
				end
			end
			ST_CALC: begin
				wt_q  <= wt_nxt;
				tat_q <= time_q[pts_pkg::FIELD_W-1:0];
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_idx_q  <= pts_pkg::out_idx_t'(pick_q);
					out_wt_q   <= wt_q;
					out_tat_q  <= tat_q;
					out_wsum_q <= wait_sum_nxt;
					out_tsum_q <= tat_sum_nxt;
					out_done_q <= all_done_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.idle        = (state_q == ST_IDLE);
	assign sts.entry_count = entry_count_q;
	assign sts.done_count  = done_count_q;

	assign out_valid        = out_valid_q;
	assign process_index    = out_idx_q;
	assign waiting_time     = out_wt_q;
	assign turnaround_time  = out_tat_q;
	assign total_wait       = out_wsum_q;
	assign total_turnaround = out_tsum_q;
	assign all_done         = out_done_q;

endmodule

`default_nettype wire

>>> hdl/priority_tick_scheduler_top.sv
// A clear or a load is registered into the command queue, then updates the table when the
// idle back end takes it; a completing tick shows its result after scan, step, calc, emit.
// The back end scans one table entry per cycle, then steps, forms the times, registers.
// The back end takes a new command only while idle: a tick holds off the next through its
// scan and step, and calc and emit when it completes an entry, longer while a result waits.
// Reset: arst_n clears the queue, counters, time, totals and output valid; table undefined.
`default_nettype none

module priority_tick_scheduler_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] burst_time,
	input  wire logic [15:0] priority_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       process_index,
	output logic [19:0]      waiting_time,
	output logic [19:0]      turnaround_time,
	output logic [23:0]      total_wait,
	output logic [23:0]      total_turnaround,
	output logic             all_done
);

	logic          cmd_valid;
	logic          cmd_ready;
	pts_pkg::cmd_t cmd;
	pts_pkg::sts_t sts;

	// Accept, classify and queue items
	pts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.burst_time   (burst_time),
		.priority_req (priority_req),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	// Execute commands and hold results
	pts_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.process_index    (process_index),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.total_wait       (total_wait),
		.total_turnaround (total_turnaround),
		.all_done         (all_done)
	);

	// Completed entries never outnumber loaded ones, and the table never overfills
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.done_count <= sts.entry_count) &&
		(sts.entry_count <= pts_pkg::cnt_t'(pts_pkg::MAX_PROCESSES)))
		else $error("done or entry count out of range");

	// A new result only comes out of a tick in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!sts.idle))
		else $error("result without a tick in progress");

	// A new result always counts a completed entry
	a_result_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (sts.done_count != '0))
		else $error("result without completed entry");

endmodule

`default_nettype wire

>>> bench/sched_checker.sv
module sched_checker
	import pts_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] burst_time,
	input  wire logic [15:0] priority_req,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [3:0]  process_index,
	input  wire logic [19:0] waiting_time,
	input  wire logic [19:0] turnaround_time,
	input  wire logic [23:0] total_wait,
	input  wire logic [23:0] total_turnaround,
	input  wire logic        all_done,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		out_idx_t idx;
		field_t   wt;
		field_t   tat;
		sum_t     sum_wt;
		sum_t     sum_tat;
		logic     done;
	} completion_t;

	// Shadow copy of the process table and the scheduler counters
	burst_t tbl_burst [MAX_PROCESSES];
	prio_t  tbl_prio  [MAX_PROCESSES];
	burst_t tbl_left  [MAX_PROCESSES];
	cnt_t   n_loaded;
	cnt_t   n_done;
	time_t  now;
	sum_t   acc_wait;
	sum_t   acc_tat;

	completion_t completion_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fail_count++;
	endtask

	// Drop the table, time and totals
	task automatic clear_table();
		for (int i = 0; i < MAX_PROCESSES; i++) begin
			tbl_burst[i] = '0;
			tbl_prio[i]  = '0;
			tbl_left[i]  = '0;
		end
		n_loaded = '0;
		n_done   = '0;
		now      = '0;
		acc_wait = '0;
		acc_tat  = '0;
	endtask

	// Advance the shadow scheduler by one accepted command
	task automatic apply_command(input logic [1:0] m, input logic [15:0] b,
			input logic [15:0] p);
		burst_t      lb;
		idx_t        pick;
		logic        found;
		time_t       diff;
		completion_t c;
		lb    = burst_t'(b);
		pick  = '0;
		found = 1'b0;
		case (mode_t'(m))
			MODE_CLEAR: begin
				clear_table();
			end
			MODE_LOAD: begin
				if (n_loaded < MAX_PROCESSES && lb != '0) begin
					tbl_burst[n_loaded] = lb;
					tbl_prio[n_loaded]  = p;
					tbl_left[n_loaded]  = lb;
					n_loaded++;
				end
			end
			MODE_TICK: begin
				// Lowest priority value wins, ties to the lowest index
				for (int i = 0; i < MAX_PROCESSES; i++) begin
					if (i < n_loaded && tbl_left[i] != '0 &&
							(!found || tbl_prio[i] < tbl_prio[pick])) begin
						found = 1'b1;
						pick  = idx_t'(i);
					end
				end
				if (found) begin
					tbl_left[pick]--;
					now++;
					if (tbl_left[pick] == '0) begin
						n_done++;
						diff      = now - time_t'(tbl_burst[pick]);
						c.idx     = out_idx_t'(pick);
						c.wt      = diff[FIELD_W-1:0];
						c.tat     = now[FIELD_W-1:0];
						acc_wait  = acc_wait + sum_t'(c.wt);
						acc_tat   = acc_tat + sum_t'(c.tat);
						c.sum_wt  = acc_wait;
						c.sum_tat = acc_tat;
						c.done    = (n_done == n_loaded);
						completion_q.push_back(c);
					end
				end
			end
			default: ;
		endcase
	endtask

	// Compare one result transfer with the oldest predicted completion
	task automatic check_completion();
		completion_t c;
		if (completion_q.size() == 0) begin
			report($sformatf("unexpected result, process_index %0d", process_index));
		end else begin
			c = completion_q.pop_front();
			if (process_index !== c.idx)
				report($sformatf("process_index got %0d want %0d", process_index, c.idx));
			if (waiting_time !== c.wt)
				report($sformatf("waiting_time got %0d want %0d", waiting_time, c.wt));
			if (turnaround_time !== c.tat)
				report($sformatf("turnaround_time got %0d want %0d",
					turnaround_time, c.tat));
			if (total_wait !== c.sum_wt)
				report($sformatf("total_wait got %0d want %0d", total_wait, c.sum_wt));
			if (total_turnaround !== c.sum_tat)
				report($sformatf("total_turnaround got %0d want %0d",
					total_turnaround, c.sum_tat));
			if (all_done !== c.done)
				report($sformatf("all_done got %0b want %0b", all_done, c.done));
		end
	endtask

	// Watch both channels at each rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			clear_table();
			completion_q.delete();
		end else begin
			if (out_valid && out_ready)
				check_completion();
			if (in_valid && in_ready)
				apply_command(mode, burst_time, priority_req);
		end
		pending = completion_q.size();
	end

endmodule

>>> bench/tb.sv
module tb;
	import pts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  mode;
	logic [15:0] burst_time;
	logic [15:0] priority_req;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  process_index;
	logic [19:0] waiting_time;
	logic [19:0] turnaround_time;
	logic [23:0] total_wait;
	logic [23:0] total_turnaround;
	logic        all_done;
	int          fail_count;
	int          pending;

	int n_sent    = 0;
	int phase     = 0;
	int send_idle = 23;
	int recv_idle = 69;

	priority_tick_scheduler_top i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.burst_time       (burst_time),
		.priority_req     (priority_req),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.process_index    (process_index),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.total_wait       (total_wait),
		.total_turnaround (total_turnaround),
		.all_done         (all_done)
	);

	sched_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.burst_time       (burst_time),
		.priority_req     (priority_req),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.process_index    (process_index),
		.waiting_time     (waiting_time),
		.turnaround_time  (turnaround_time),
		.total_wait       (total_wait),
		.total_turnaround (total_turnaround),
		.all_done         (all_done),
		.fail_count       (fail_count),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the whole run
	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	// Result side: random back-pressure plus one long hold-off in the last phase
	initial begin
		int   hold_left;
		logic held_once;
		hold_left = 0;
		held_once = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_once && phase == 2) begin
				hold_left = 800;
				held_once = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Offer one command and hold it until the transfer
	task automatic push_item(input logic [1:0] m, input logic [15:0] b,
			input logic [15:0] p);
		phase = (n_sent < 550) ? 0 : (n_sent < 1100) ? 1 : 2;
		case (phase)
			0: begin send_idle = 23; recv_idle = 69; end
			1: begin send_idle = 69; recv_idle = 23; end
			default: begin send_idle = 0; recv_idle = 0; end
		endcase
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		burst_time   <= b;
		priority_req <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (m != MODE_NONE)
			n_sent++;
	endtask

	// Load one entry, mostly short bursts; track the ticks it needs
	task automatic load_random(inout int owed);
		int          r;
		logic [15:0] b;
		logic [15:0] p;
		r = $urandom_range(99);
		if (r < 85) begin
			b = 16'($urandom_range(1, 6));
			owed += b;
		end else if (r < 90) begin
			b = '0;
		end else begin
			b = 16'($urandom);
		end
		p = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
		push_item(MODE_LOAD, b, p);
	endtask

	initial begin
		int k;
		int owed;
		int n;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_CLEAR;
		burst_time   = '0;
		priority_req = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty tick, unused mode, zero burst, extremes, ties, preemption
		push_item(MODE_TICK, 16'h0000, 16'h0000);
		push_item(MODE_NONE, 16'hffff, 16'hffff);
		push_item(MODE_LOAD, 16'h0000, 16'h1234);
		push_item(MODE_LOAD, 16'hffff, 16'hffff);
		push_item(MODE_LOAD, 16'h0001, 16'h0000);
		push_item(MODE_TICK, 16'hffff, 16'hffff);
		push_item(MODE_LOAD, 16'h0002, 16'h0005);
		push_item(MODE_LOAD, 16'h0002, 16'h0005);
		repeat (5) push_item(MODE_TICK, 16'h5a5a, 16'ha5a5);
		push_item(MODE_CLEAR, 16'hffff, 16'hffff);
		push_item(MODE_TICK, 16'h0000, 16'h0000);
		push_item(MODE_LOAD, 16'h0003, 16'h8000);
		repeat (4) push_item(MODE_TICK, 16'h0000, 16'hffff);

		// Random: mostly clear-load-serve sequences, some noise
		while (n_sent < 1650) begin
			if ($urandom_range(99) < 8) begin
				push_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
			end else begin
				if ($urandom_range(9) != 0)
					push_item(MODE_CLEAR, 16'($urandom), 16'($urandom));
				k = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
				owed = 0;
				for (int j = 0; j < k; j++)
					load_random(owed);
				owed += $urandom_range(0, 3);
				for (int j = 0; j < owed; j++) begin
					if ($urandom_range(19) == 0)
						load_random(owed);
					push_item(MODE_TICK, 16'($urandom), 16'($urandom));
				end
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain outstanding completions, then let the pipeline settle
		n = 0;
		while (pending != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/pts_pkg.sv
hdl/pts_front.sv
hdl/pts_back.sv
hdl/priority_tick_scheduler_top.sv
bench/sched_checker.sv
bench/tb.sv
